// ===== sv/csem_pkg.sv =====
// shared types and codes for the counting semaphore block
// no dependencies
package csem_pkg;

  localparam int unsigned MaxThreadsDef = 64;
  localparam int unsigned TidW          = 8;
  localparam int unsigned InitW         = 7;
  localparam int unsigned CountOutW     = 8;

  typedef enum logic [1:0] {
    CmdWait    = 2'd0,
    CmdTryWait = 2'd1,
    CmdPost    = 2'd2,
    CmdDestroy = 2'd3
  } csem_cmd_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBlocked  = 3'd1,
    StDeadlock = 3'd2,
    StInvalid  = 3'd3,
    StAgain    = 3'd4,
    StBusy     = 3'd5,
    StQueueFull = 3'd6
  } csem_status_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } csem_fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } csem_fifo_stat_t;

  typedef struct packed {
    logic signed [CountOutW-1:0] count_now;
    logic [TidW-1:0]             woken_thread;
    csem_status_e                status;
  } csem_result_t;

endpackage

// ===== sv/csem_fifo.sv =====
// wait queue of blocked thread ids: memory, pointers and prefetched head word
// depends on csem_pkg
module csem_fifo #(
  parameter int unsigned MAX_THREADS = csem_pkg::MaxThreadsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  csem_pkg::csem_fifo_ctrl_t ctrl_i,
  input  logic [csem_pkg::TidW-1:0] push_data_i,
  output logic [csem_pkg::TidW-1:0] head_word_o,
  output csem_pkg::csem_fifo_stat_t stat_o
);
  import csem_pkg::*;

  localparam int unsigned PtrW  = $clog2(MAX_THREADS);
  localparam int unsigned UsedW = $clog2(MAX_THREADS + 1);
  localparam logic [PtrW-1:0]  LastSlot = PtrW'(MAX_THREADS - 1);
  localparam logic [UsedW-1:0] FullCnt  = UsedW'(MAX_THREADS);

  logic [TidW-1:0]  mem_q [MAX_THREADS];
  logic [TidW-1:0]  head_word_q;
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [UsedW-1:0] used_q, used_d;

  function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
    return (p == LastSlot) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    used_d = used_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
      used_d = '0;
    end else if (ctrl_i.push) begin
      tail_d = next_slot(tail_q);
      used_d = used_q + UsedW'(1);
    end else if (ctrl_i.pop) begin
      head_d = next_slot(head_q);
      used_d = used_q - UsedW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
  end

  // head word follows the next head, bypassing a write to the same slot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (tail_q == head_d)) begin
      head_word_q <= push_data_i;
    end else begin
      head_word_q <= mem_q[head_d];
    end
  end

  assign head_word_o  = head_word_q;
  assign stat_o.empty = (used_q == '0);
  assign stat_o.full  = (used_q >= FullCnt);

endmodule

// ===== sv/csem_core.sv =====
// semaphore state (count, owner, initial value) and per-word decision logic
// depends on csem_pkg and csem_fifo
module csem_core #(
  parameter int unsigned MAX_THREADS = csem_pkg::MaxThreadsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csem_pkg::InitW-1:0] cfg_wdata_i,
  input  logic                       fire_i,
  input  csem_pkg::csem_cmd_e        cmd_i,
  input  logic [csem_pkg::TidW-1:0]  tid_i,
  output csem_pkg::csem_result_t     result_o
);
  import csem_pkg::*;

  localparam int unsigned CntMinW = $clog2(MAX_THREADS + 1) + 1;
  localparam int unsigned CntW    = (CntMinW > CountOutW) ? CntMinW : CountOutW;
  localparam logic signed [CntW-1:0] One    = CntW'(1);
  localparam logic signed [CntW-1:0] Zero   = '0;
  localparam logic signed [CntW-1:0] MaxCnt = CntW'(MAX_THREADS);
  localparam logic [InitW-1:0]       BinInit = InitW'(1);

  logic [InitW-1:0]        init_q;
  logic signed [CntW-1:0]  count_q, count_d, cnt_inc, cnt_dec, init_ext, cfg_ext;
  logic [TidW-1:0]         owner_q, owner_d, woken;
  logic                    binary, dead, cfg_ok;
  csem_status_e            status;
  csem_fifo_ctrl_t         fifo_ctrl;
  csem_fifo_stat_t         fifo_stat;
  logic [TidW-1:0]         head_word;

  csem_fifo #(
    .MAX_THREADS(MAX_THREADS)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (fifo_ctrl),
    .push_data_i(tid_i),
    .head_word_o(head_word),
    .stat_o     (fifo_stat)
  );

  assign init_ext = signed'({{(CntW - InitW){1'b0}}, init_q});
  assign cfg_ext  = signed'({{(CntW - InitW){1'b0}}, cfg_wdata_i});
  assign cfg_ok   = cfg_we_i && (cfg_ext <= MaxCnt);
  assign cnt_inc  = count_q + One;
  assign cnt_dec  = count_q - One;
  assign binary   = (init_q == BinInit);
  assign dead     = binary && (count_q != One) && (owner_q == tid_i);

  always_comb begin
    count_d         = count_q;
    owner_d         = owner_q;
    woken           = '0;
    status          = StOk;
    fifo_ctrl.push  = 1'b0;
    fifo_ctrl.pop   = 1'b0;
    fifo_ctrl.clear = cfg_ok;
    if (tid_i == '0) begin
      status = StInvalid;
    end else begin
      case (cmd_i)
        CmdWait: begin
          if (dead) begin
            status = StDeadlock;
          end else if (count_q >= One) begin
            count_d = cnt_dec;
            owner_d = tid_i;
          end else if (fifo_stat.full) begin
            status = StQueueFull;
          end else begin
            count_d        = cnt_dec;
            fifo_ctrl.push = fire_i;
            status         = StBlocked;
          end
        end
        CmdTryWait: begin
          if (dead) begin
            status = StDeadlock;
          end else if (count_q > Zero) begin
            count_d = cnt_dec;
            owner_d = tid_i;
          end else begin
            status = StAgain;
          end
        end
        CmdPost: begin
          if (binary && ((count_q > Zero) || (owner_q != tid_i))) begin
            status = StInvalid;
          end else if (count_q >= MaxCnt) begin
            status = StInvalid;
          end else begin
            count_d = cnt_inc;
            if ((cnt_inc <= Zero) && !fifo_stat.empty) begin
              woken         = head_word;
              fifo_ctrl.pop = fire_i;
            end
            owner_d = woken;
          end
        end
        CmdDestroy: begin
          if (count_q != init_ext) begin
            status = StBusy;
          end else begin
            owner_d = '0;
          end
        end
        default: status = StInvalid;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= BinInit;
      count_q <= One;
      owner_q <= '0;
    end else if (cfg_ok) begin
      init_q  <= cfg_wdata_i;
      count_q <= cfg_ext;
      owner_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
      owner_q <= owner_d;
    end
  end

  assign result_o.status       = status;
  assign result_o.woken_thread = woken;
  assign result_o.count_now    = count_d[CountOutW-1:0];

endmodule

// ===== sv/counting_semaphore_with_wait_fifo.sv =====
// top level of the counting semaphore with a queue of blocked threads
// depends on csem_pkg and csem_core
//
// Hardware counting semaphore. Each input word carries a command (wait,
// trywait, post, destroy) and a nonzero thread id; each gives exactly one
// result word with a status, the thread woken by a post and the count after
// the command. Words flow through an input register and a result register:
// one word per cycle is sustained while m_axis_tready is high, set by the
// single state update per cycle and the prefetched wait queue head; results
// enter the result register when it is free or read. Writing the initial
// value loads the count, clears the owner, empties the queue; a value above
// MAX_THREADS is ignored. Write it only while no words are in flight.
module counting_semaphore_with_wait_fifo #(
  parameter int unsigned MAX_THREADS = csem_pkg::MaxThreadsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [csem_pkg::InitW-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [1:0] command, [9:2] thread_id, [15:10] zero
  input  logic [15:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [2:0] status, [10:3] woken_thread, [18:11] count_now, [23:19] zero
  output logic [23:0]                m_axis_tdata
);
  import csem_pkg::*;

  logic            in_valid_q, out_valid_q, advance;
  csem_cmd_e       in_cmd_q;
  logic [TidW-1:0] in_tid_q;
  csem_result_t    res, out_res_q;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  csem_core #(
    .MAX_THREADS(MAX_THREADS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (advance),
    .cmd_i      (in_cmd_q),
    .tid_i      (in_tid_q),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= csem_cmd_e'(s_axis_tdata[1:0]);
      in_tid_q <= s_axis_tdata[9:2];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.count_now, out_res_q.woken_thread,
                          out_res_q.status};

`ifndef SYNTHESIS
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |=> out_valid_q)
    else $error("pending word did not move to result register");

  a_woken_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.woken_thread != '0) |-> out_res_q.status == StOk)
    else $error("woken thread reported with non-ok status");

  a_blocked_is_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res.status == StBlocked) |-> in_cmd_q == CmdWait)
    else $error("blocked status from a command other than wait");
`endif

endmodule
